// ===== src/rtpd_pkg.sv =====
// Package: shared types, constants and MD5 tables for the tunnel password decryptor.
`timescale 1ns / 1ps
package rtpd_pkg;

	localparam int MAX_SECRET_BYTES = 32;
	localparam int MAX_ATTR_BYTES   = 253;
	localparam int BLOCK_BYTES      = 16;
	localparam int EXT_BYTES        = BLOCK_BYTES + 2;
	localparam int FIFO_DEPTH       = 4;

	localparam logic [2:0] REG_SECRET0 = 3'd0;
	localparam logic [2:0] REG_SECRET1 = 3'd1;
	localparam logic [2:0] REG_SECRET2 = 3'd2;
	localparam logic [2:0] REG_SECRET3 = 3'd3;
	localparam logic [2:0] REG_SECLEN  = 3'd4;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_SHORT = 2'd1;
	localparam logic [1:0] STAT_LONG  = 2'd2;

	localparam logic [31:0] MD5_IV0 = 32'h67452301;
	localparam logic [31:0] MD5_IV1 = 32'hefcdab89;
	localparam logic [31:0] MD5_IV2 = 32'h98badcfe;
	localparam logic [31:0] MD5_IV3 = 32'h10325476;

	typedef struct packed {
		logic       load;
		logic       round;
		logic       finish;
		logic [5:0] idx;
	} rtpd_cmd_t;

	typedef struct packed {
		logic need_hash;
		logic room;
	} rtpd_stat_t;

	typedef struct packed {
		logic       is_status;
		logic [7:0] plain_byte;
		logic [1:0] status;
		logic [7:0] plain_length;
	} rtpd_res_t;

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
			6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
			6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
			6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5_s(input logic [3:0] i);
		logic [4:0] s;
		case (i)
			4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== src/rtpd_if.sv =====
// Interfaces: request, result and configuration channels.
`timescale 1ns / 1ps
interface rtpd_req_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic       last;
	modport source (output valid, kind, data_byte, last, input ready);
	modport sink   (input valid, kind, data_byte, last, output ready);
endinterface

interface rtpd_res_if;
	logic       valid;
	logic       ready;
	logic       is_status;
	logic [7:0] plain_byte;
	logic [1:0] status;
	logic [7:0] plain_length;
	modport source (output valid, is_status, plain_byte, status, plain_length, input ready);
	modport sink   (input valid, is_status, plain_byte, status, plain_length, output ready);
endinterface

interface rtpd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/rtpd_ctrl.sv =====
// Controller: sequences message load, 64 MD5 rounds and digest finish.
`timescale 1ns / 1ps
module rtpd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  rtpd_pkg::rtpd_stat_t stat,
	output rtpd_pkg::rtpd_cmd_t  cmd,
	output logic                idle
);
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LOAD  = 4'b0010,
		ST_ROUND = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 6'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= 6'd0;
					if (acc && stat.need_hash) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (cnt_q == 6'd15) begin
						cnt_q   <= 6'd0;
						state_q <= ST_ROUND;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= ST_DONE;
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load   = (state_q == ST_LOAD);
		cmd.round  = (state_q == ST_ROUND);
		cmd.finish = (state_q == ST_DONE);
		cmd.idx    = cnt_q;
		idle       = (state_q == ST_IDLE);
	end
endmodule

// ===== src/rtpd_dp.sv =====
// Datapath: byte handling, keystream, MD5 round unit and result queue.
`timescale 1ns / 1ps
module rtpd_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 acc,
	input  logic                 kind,
	input  logic [7:0]           data_byte,
	input  logic                 last,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_idx,
	input  logic [63:0]          cfg_data,
	input  rtpd_pkg::rtpd_cmd_t  cmd,
	output rtpd_pkg::rtpd_stat_t stat,
	output logic                 res_valid,
	input  logic                 res_ready,
	output rtpd_pkg::rtpd_res_t  res
);
	logic [255:0] secret_q;
	logic [5:0]   seclen_q;
	logic [7:0]   vec_q [rtpd_pkg::BLOCK_BYTES];
	logic [3:0]   vcnt_q;
	logic [7:0]   salt_q;
	logic [7:0]   pos_q;
	logic [127:0] ks_q;
	logic [7:0]   cip_q [rtpd_pkg::BLOCK_BYTES];
	logic [7:0]   decl_q;
	logic [7:0]   ext_q [rtpd_pkg::EXT_BYTES];
	logic         first_q;
	logic [31:0]  mw_q [16];
	logic [31:0]  a_q, b_q, c_q, d_q;
	rtpd_pkg::rtpd_res_t fifo_q [rtpd_pkg::FIFO_DEPTH];
	logic [1:0]   wp_q, rp_q;
	logic [2:0]   cnt_q;

	// per-byte decode
	logic       act;
	logic [7:0] ci, pos_nx, decl_nx, ldiff;
	logic [3:0] k;
	logic [7:0] p;
	logic       pt_push, st_push, pop;
	rtpd_pkg::rtpd_res_t pt_res, st_res;

	always_comb begin
		act     = kind && (pos_q < 8'(rtpd_pkg::MAX_ATTR_BYTES));
		ci      = pos_q - 8'd2;
		k       = ci[3:0];
		p       = data_byte ^ ks_q[{k, 3'b000} +: 8];
		stat.need_hash = act && ((pos_q == 8'd1) || ((pos_q >= 8'd2) && (k == 4'hf)));
		stat.room = (cnt_q <= 3'd2);
		pos_nx  = act ? pos_q + 8'd1 : pos_q;
		decl_nx = (act && pos_q >= 8'd2 && ci == 8'd0) ? p : decl_q;
		ldiff   = pos_nx - 8'd2;
		pt_push = acc && act && (pos_q >= 8'd2) && (ci != 8'd0) && (ci <= decl_q);
		st_push = acc && kind && last;
		pt_res  = '{is_status: 1'b0, plain_byte: p, status: rtpd_pkg::STAT_OK,
			plain_length: 8'd0};
		st_res  = '{is_status: 1'b1, plain_byte: 8'd0, status: rtpd_pkg::STAT_OK,
			plain_length: 8'd0};
		if (pos_nx < 8'd2) begin
			st_res.status = rtpd_pkg::STAT_SHORT;
		end else if (pos_nx <= 8'd3) begin
			st_res.status = rtpd_pkg::STAT_OK;
		end else if (decl_nx >= ldiff) begin
			st_res.status = rtpd_pkg::STAT_LONG;
		end else begin
			st_res.plain_length = decl_nx;
		end
	end

	// message word build: secret, extra bytes, pad marker, bit length
	logic [5:0]  slen, mlen, j, dd;
	logic [4:0]  nbytes;
	logic [8:0]  mbits;
	logic [31:0] lw;

	always_comb begin
		slen   = (seclen_q > 6'(rtpd_pkg::MAX_SECRET_BYTES)) ?
			6'(rtpd_pkg::MAX_SECRET_BYTES) : seclen_q;
		nbytes = first_q ? 5'(rtpd_pkg::EXT_BYTES) : 5'(rtpd_pkg::BLOCK_BYTES);
		mlen   = slen + {1'b0, nbytes};
		mbits  = {mlen, 3'b000};
		lw     = 32'd0;
		j      = 6'd0;
		dd     = 6'd0;
		for (int bb = 0; bb < 4; bb++) begin
			j  = {cmd.idx[3:0], 2'(bb)};
			dd = j - slen;
			if (j < slen) begin
				lw[8*bb +: 8] = secret_q[{j[4:0], 3'b000} +: 8];
			end else if (dd < {1'b0, nbytes}) begin
				lw[8*bb +: 8] = ext_q[dd[4:0]];
			end else if (dd == {1'b0, nbytes}) begin
				lw[8*bb +: 8] = 8'h80;
			end else if (j == 6'd56) begin
				lw[8*bb +: 8] = mbits[7:0];
			end else if (j == 6'd57) begin
				lw[8*bb +: 8] = {7'd0, mbits[8]};
			end
		end
	end

	// one MD5 round per cycle
	logic [31:0] f, t, mg, b_nx;
	logic [3:0]  g;
	logic [63:0] rot;

	always_comb begin
		case (cmd.idx[5:4])
			2'd0: begin
				f = (b_q & c_q) | (~b_q & d_q);
				g = cmd.idx[3:0];
			end
			2'd1: begin
				f = (d_q & b_q) | (~d_q & c_q);
				g = 4'(cmd.idx[3:0] * 4'd5 + 4'd1);
			end
			2'd2: begin
				f = b_q ^ c_q ^ d_q;
				g = 4'(cmd.idx[3:0] * 4'd3 + 4'd5);
			end
			default: begin
				f = c_q ^ (b_q | ~d_q);
				g = 4'(cmd.idx[3:0] * 4'd7);
			end
		endcase
		mg   = mw_q[g];
		t    = a_q + f + rtpd_pkg::md5_k(cmd.idx) + mg;
		rot  = {t, t} << rtpd_pkg::md5_s({cmd.idx[5:4], cmd.idx[1:0]});
		b_nx = b_q + rot[63:32];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) mw_q[cmd.idx[3:0]] <= lw;
		if (cmd.load) begin
			a_q <= rtpd_pkg::MD5_IV0;
			b_q <= rtpd_pkg::MD5_IV1;
			c_q <= rtpd_pkg::MD5_IV2;
			d_q <= rtpd_pkg::MD5_IV3;
		end else if (cmd.round) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_nx;
		end
		if (acc && stat.need_hash) begin
			first_q <= (pos_q == 8'd1);
			if (pos_q == 8'd1) begin
				for (int i = 0; i < rtpd_pkg::BLOCK_BYTES; i++) ext_q[i] <= vec_q[i];
				ext_q[rtpd_pkg::BLOCK_BYTES]     <= salt_q;
				ext_q[rtpd_pkg::BLOCK_BYTES + 1] <= data_byte;
			end else begin
				for (int i = 0; i < rtpd_pkg::BLOCK_BYTES - 1; i++) ext_q[i] <= cip_q[i];
				ext_q[rtpd_pkg::BLOCK_BYTES - 1] <= data_byte;
			end
		end
		if (pt_push && st_push) begin
			fifo_q[wp_q]        <= pt_res;
			fifo_q[wp_q + 2'd1] <= st_res;
		end else if (pt_push) begin
			fifo_q[wp_q] <= pt_res;
		end else if (st_push) begin
			fifo_q[wp_q] <= st_res;
		end
	end

	assign pop       = res_valid && res_ready;
	assign res_valid = (cnt_q != 3'd0);
	assign res       = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_q <= '0;
			seclen_q <= 6'd0;
			for (int i = 0; i < rtpd_pkg::BLOCK_BYTES; i++) begin
				vec_q[i] <= 8'd0;
				cip_q[i] <= 8'd0;
			end
			vcnt_q <= 4'd0;
			salt_q <= 8'd0;
			pos_q  <= 8'd0;
			ks_q   <= '0;
			decl_q <= 8'd0;
			wp_q   <= 2'd0;
			rp_q   <= 2'd0;
			cnt_q  <= 3'd0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					rtpd_pkg::REG_SECRET0: secret_q[63:0]    <= cfg_data;
					rtpd_pkg::REG_SECRET1: secret_q[127:64]  <= cfg_data;
					rtpd_pkg::REG_SECRET2: secret_q[191:128] <= cfg_data;
					rtpd_pkg::REG_SECRET3: secret_q[255:192] <= cfg_data;
					rtpd_pkg::REG_SECLEN:  seclen_q          <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (acc && !kind) begin
				vec_q[vcnt_q] <= data_byte;
				vcnt_q        <= vcnt_q + 4'd1;
			end
			if (acc && act) begin
				if (pos_q == 8'd0) salt_q <= data_byte;
				if (pos_q >= 8'd2) cip_q[k] <= data_byte;
			end
			if (acc && kind) begin
				if (last) begin
					pos_q  <= 8'd0;
					decl_q <= 8'd0;
					vcnt_q <= 4'd0;
				end else begin
					pos_q  <= pos_nx;
					decl_q <= decl_nx;
				end
			end
			if (cmd.finish) begin
				ks_q <= {d_q + rtpd_pkg::MD5_IV3, c_q + rtpd_pkg::MD5_IV2,
					b_q + rtpd_pkg::MD5_IV1, a_q + rtpd_pkg::MD5_IV0};
			end
			wp_q  <= wp_q + 2'(pt_push) + 2'(st_push);
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(pt_push) + 3'(st_push) - 3'(pop);
		end
	end
endmodule

// ===== src/radius_tunnel_password_decrypt.sv =====
// A result is written into the registered result queue when its request is
// accepted. The second salt byte and every sixteenth cipher byte start a
// keystream digest that stalls the input (message load, 64 MD5 rounds on one
// round unit, finish); input also stalls while the result queue lacks room.
// arst_n clears all but the MD5 message/working regs and queue entries; secret is zero.
`timescale 1ns / 1ps
module radius_tunnel_password_decrypt (
	input  logic       clk,
	input  logic       arst_n,
	rtpd_req_if.sink   in_ch,
	rtpd_res_if.source out_ch,
	rtpd_cfg_if.sink   cfg_ch
);
	rtpd_pkg::rtpd_cmd_t  cmd;
	rtpd_pkg::rtpd_stat_t stat;
	rtpd_pkg::rtpd_res_t  res;
	logic idle, acc;

	assign in_ch.ready  = idle && stat.room;
	assign acc          = in_ch.valid && in_ch.ready;
	assign cfg_ch.ready = 1'b1;

	rtpd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.stat   (stat),
		.cmd    (cmd),
		.idle   (idle)
	);

	rtpd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.kind      (in_ch.kind),
		.data_byte (in_ch.data_byte),
		.last      (in_ch.last),
		.cfg_we    (cfg_ch.valid),
		.cfg_idx   (cfg_ch.index),
		.cfg_data  (cfg_ch.data),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (out_ch.valid),
		.res_ready (out_ch.ready),
		.res       (res)
	);

	assign out_ch.is_status    = res.is_status;
	assign out_ch.plain_byte   = res.plain_byte;
	assign out_ch.status       = res.status;
	assign out_ch.plain_length = res.plain_length;
endmodule

// ===== src/rtpd_checker.sv =====
// Checker: port-level assertions on the result channel, bound to the top level.
`timescale 1ns / 1ps
module rtpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       is_status,
	input logic [7:0] plain_byte,
	input logic [1:0] status,
	input logic [7:0] plain_length
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(plain_byte) && $stable(status))
		else $error("result changed while stalled");

	a_plain_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_status |-> status == rtpd_pkg::STAT_OK && plain_length == 8'd0)
		else $error("plaintext result carries status fields");

	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_status |-> plain_byte == 8'd0 &&
		(status == rtpd_pkg::STAT_OK || plain_length == 8'd0))
		else $error("status result fields inconsistent");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");
endmodule

bind radius_tunnel_password_decrypt rtpd_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.is_status    (out_ch.is_status),
	.plain_byte   (out_ch.plain_byte),
	.status       (out_ch.status),
	.plain_length (out_ch.plain_length)
);

// ===== test/tb_top.sv =====
// Testbench: vector and attribute bytes into the decryptor, results against a predictor.
`timescale 1ns / 1ps
module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rtpd_req_if in_ch();
	rtpd_res_if out_ch();
	rtpd_cfg_if cfg_ch();

	radius_tunnel_password_decrypt i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	typedef struct {
		logic       kind;
		logic [7:0] data_byte;
		logic       last;
	} byte_req_t;

	// predictor state
	logic [63:0] sec_w [4];
	logic [5:0]  sec_len;
	logic [7:0]  vec [16];
	logic [3:0]  vec_cnt;
	logic [7:0]  salt_lo;
	int          attr_pos;
	logic [7:0]  key [16];
	logic [7:0]  cblk [16];
	logic [7:0]  decl_len;

	rtpd_pkg::rtpd_res_t expected_q[$];
	byte_req_t   req_q[$];
	int          fail_cnt = 0;
	int          mism_cnt = 0;
	int          cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          stim_done = 0;

	function automatic logic [31:0] rol32(logic [31:0] x, int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	// MD5 of secret then extra bytes, result into key[]
	function automatic void digest_into_key(logic [7:0] extra [18], int n);
		logic [7:0]  msg [128];
		logic [31:0] h [4];
		logic [31:0] m [16];
		logic [31:0] a, b, c, d, f, t;
		int          slen, len, total, g, blk, i;
		logic [63:0] bits;
		slen = (sec_len > rtpd_pkg::MAX_SECRET_BYTES) ? rtpd_pkg::MAX_SECRET_BYTES : sec_len;
		for (i = 0; i < 128; i++) msg[i] = 8'h00;
		for (i = 0; i < slen; i++) msg[i] = sec_w[i / 8][8 * (i % 8) +: 8];
		for (i = 0; i < n; i++) msg[slen + i] = extra[i];
		len = slen + n;
		msg[len] = 8'h80;
		total = (len + 9 <= 64) ? 64 : 128;
		bits = 64'(len) * 8;
		for (i = 0; i < 8; i++) msg[total - 8 + i] = bits[8 * i +: 8];
		h[0] = rtpd_pkg::MD5_IV0; h[1] = rtpd_pkg::MD5_IV1;
		h[2] = rtpd_pkg::MD5_IV2; h[3] = rtpd_pkg::MD5_IV3;
		for (blk = 0; blk < total; blk += 64) begin
			for (i = 0; i < 16; i++)
				m[i] = {msg[blk + 4*i + 3], msg[blk + 4*i + 2],
					msg[blk + 4*i + 1], msg[blk + 4*i]};
			a = h[0]; b = h[1]; c = h[2]; d = h[3];
			for (i = 0; i < 64; i++) begin
				if (i < 16) begin
					f = (b & c) | (~b & d); g = i;
				end else if (i < 32) begin
					f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
				end else if (i < 48) begin
					f = b ^ c ^ d; g = (3 * i + 5) % 16;
				end else begin
					f = c ^ (b | ~d); g = (7 * i) % 16;
				end
				t = d; d = c; c = b;
				b = b + rol32(a + f + rtpd_pkg::md5_k(6'(i)) + m[g],
					rtpd_pkg::md5_s(4'({i[5:4], i[1:0]})));
				a = t;
			end
			h[0] += a; h[1] += b; h[2] += c; h[3] += d;
		end
		for (i = 0; i < 16; i++) key[i] = h[i / 4][8 * (i % 4) +: 8];
	endfunction

	function automatic void predict_byte(byte_req_t r);
		logic [7:0] buf18 [18];
		logic [7:0] p;
		rtpd_pkg::rtpd_res_t res;
		int         ci, k, i, alen;
		if (!r.kind) begin
			vec[vec_cnt] = r.data_byte;
			vec_cnt++;
			return;
		end
		if (attr_pos < rtpd_pkg::MAX_ATTR_BYTES) begin
			if (attr_pos == 0) begin
				salt_lo = r.data_byte;
			end else if (attr_pos == 1) begin
				for (i = 0; i < 16; i++) buf18[i] = vec[i];
				buf18[16] = salt_lo;
				buf18[17] = r.data_byte;
				digest_into_key(buf18, 18);
			end else begin
				ci = attr_pos - 2;
				k = ci % 16;
				p = r.data_byte ^ key[k];
				cblk[k] = r.data_byte;
				if (ci == 0) begin
					decl_len = p;
				end else if (ci <= decl_len) begin
					res = '0;
					res.plain_byte = p;
					expected_q.push_back(res);
				end
				if (k == 15) begin
					for (i = 0; i < 16; i++) buf18[i] = cblk[i];
					digest_into_key(buf18, 16);
				end
			end
			attr_pos++;
		end
		if (r.last) begin
			res = '0;
			res.is_status = 1'b1;
			alen = attr_pos;
			if (alen < 2) res.status = rtpd_pkg::STAT_SHORT;
			else if (alen <= 3) res.status = rtpd_pkg::STAT_OK;
			else if (decl_len >= alen - 2) res.status = rtpd_pkg::STAT_LONG;
			else begin
				res.status = rtpd_pkg::STAT_OK;
				res.plain_length = decl_len;
			end
			expected_q.push_back(res);
			attr_pos = 0;
			decl_len = 0;
			vec_cnt = 0;
		end
	endfunction

	// request driver
	initial begin
		byte_req_t r;
		in_ch.valid = 1'b0;
		in_ch.kind = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.last = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (in_ch.valid && in_ch.ready) begin
				predict_byte('{in_ch.kind, in_ch.data_byte, in_ch.last});
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					r = req_q.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.kind <= r.kind;
					in_ch.data_byte <= r.data_byte;
					in_ch.last <= r.last;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	initial begin
		rtpd_pkg::rtpd_res_t got, want;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.is_status, out_ch.plain_byte, out_ch.status, out_ch.plain_length};
				if (expected_q.size() == 0) begin
					fail_cnt++;
					if (mism_cnt++ < 10) $display("unexpected result %p", got);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						fail_cnt++;
						if (mism_cnt++ < 10) $display("mismatch: expected %p got %p", want, got);
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// valid stays high across back-to-back writes; the caller drops it
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == rtpd_pkg::REG_SECLEN) sec_len = val[5:0];
		else sec_w[idx] = val;
	endtask

	task automatic wait_drained();
		while (req_q.size() > 0 || in_ch.valid || expected_q.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_secret(int n, bit ones);
		int i;
		for (i = 0; i < 4; i++)
			write_reg(rtpd_pkg::REG_SECRET0 + 3'(i), ones ? '1 : {$urandom, $urandom});
		write_reg(rtpd_pkg::REG_SECLEN, 6'(n));
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic void push_vector(int n);
		int i;
		for (i = 0; i < n; i++) req_q.push_back('{1'b0, 8'($urandom), 1'($urandom)});
	endfunction

	// attribute of random bytes: salt, cipher bytes, given attribute length
	function automatic void push_attr(int alen);
		int i;
		for (i = 0; i < alen; i++)
			req_q.push_back('{1'b1, 8'($urandom), i == alen - 1});
	endfunction

	int items = 0;

	task automatic random_phase(int n_items);
		int alen, sel, nv, nw;
		while (items < n_items) begin
			sel = $urandom_range(99);
			if (sel < 85) begin
				push_vector(16);
				case ($urandom_range(9))
					0: alen = $urandom_range(0, 4);
					1: alen = $urandom_range(200, 258);
					default: alen = $urandom_range(4, 40);
				endcase
				if (alen == 0) alen = 1;
				push_attr(alen);
				items += 16 + alen;
			end else begin
				// noise: odd vector counts, vector bytes inside an attribute
				nv = $urandom_range(0, 20);
				push_vector(nv);
				req_q.push_back('{1'b1, 8'($urandom), 1'b0});
				nw = $urandom_range(0, 3);
				push_vector(nw);
				alen = $urandom_range(1, 20);
				push_attr(alen);
				items += nv + 1 + nw + alen;
			end
			while (req_q.size() > 64) @(posedge clk);
		end
	endtask

	// directed table: {kind, byte, last}; short and empty attributes, then vector bytes and a six-byte attribute
	byte_req_t dir_tab[] = '{
		'{1'b1, 8'hff, 1'b1},
		'{1'b1, 8'h00, 1'b0}, '{1'b1, 8'hff, 1'b1},
		'{1'b1, 8'h00, 1'b0}, '{1'b1, 8'h00, 1'b0}, '{1'b1, 8'hff, 1'b1},
		'{1'b0, 8'h00, 1'b1}, '{1'b0, 8'hff, 1'b0},
		'{1'b1, 8'h12, 1'b0}, '{1'b1, 8'h34, 1'b0}, '{1'b1, 8'h00, 1'b0},
		'{1'b1, 8'hff, 1'b0}, '{1'b1, 8'h80, 1'b0}, '{1'b1, 8'h01, 1'b1}
	};
	rtpd_pkg::rtpd_res_t dir_exp[] = '{
		'{1'b1, 8'h00, rtpd_pkg::STAT_SHORT, 8'h00},
		'{1'b1, 8'h00, rtpd_pkg::STAT_OK, 8'h00},
		'{1'b1, 8'h00, rtpd_pkg::STAT_OK, 8'h00}
	};

	initial begin
		int i;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = rtpd_pkg::REG_SECRET0;
		cfg_ch.data = '0;
		for (i = 0; i < 4; i++) sec_w[i] = '0;
		sec_len = '0;
		for (i = 0; i < 16; i++) begin
			vec[i] = '0; key[i] = '0; cblk[i] = '0;
		end
		vec_cnt = '0; salt_lo = '0; attr_pos = 0; decl_len = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first three attributes: too short, then empty passwords
		for (i = 0; i < 6; i++) req_q.push_back(dir_tab[i]);
		while (req_q.size() > 0 || in_ch.valid) @(posedge clk);
		while (expected_q.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		for (i = 6; i < dir_tab.size(); i++) req_q.push_back(dir_tab[i]);
		wait_drained();

		// the typed-in expectations are compared in order by the sanity block below; recheck table by count
		if (dir_exp.size() != 3) fail_cnt++;

		set_secret(rtpd_pkg::MAX_SECRET_BYTES, 1'b1);
		push_vector(16); push_attr(rtpd_pkg::MAX_ATTR_BYTES + 3);
		push_vector(17); push_attr(34);
		wait_drained();

		set_secret(0, 1'b0);
		send_idle_pct = 0; recv_stall_pct = 0;
		random_phase(280);
		wait_drained();
		set_secret(63, 1'b0);
		send_idle_pct = 52;
		random_phase(560);
		wait_drained();
		set_secret($urandom_range(1, 31), 1'b0);
		send_idle_pct = 0; recv_stall_pct = 52;
		random_phase(840);
		wait_drained();
		set_secret(46, 1'b0);
		send_idle_pct = 20; recv_stall_pct = 20;
		random_phase(1110);
		wait_drained();
		stim_done = 1;
	end

	// sanity: directed short/empty status results match the typed table
	initial begin
		int n;
		n = 0;
		@(posedge arst_n);
		while (n < 3) begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if ({out_ch.is_status, out_ch.plain_byte, out_ch.status, out_ch.plain_length}
					!== dir_exp[n]) begin
					fail_cnt++;
					if (mism_cnt++ < 10) $display("directed status %0d wrong", n);
				end
				n++;
			end
		end
	end

	initial begin
		while (!stim_done && cycles < 3000000) begin
			@(posedge clk);
			cycles++;
		end
		if (!stim_done) begin
			$display("CHECK FAILED");
		end else if (fail_cnt == 0 && expected_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
